// ----- hw/rtl/thp_sensor_compensation_top_defines.svh -----
// Assertion macros used by the checker of the compensation block.
// Expects clk_i and rst_ni to be visible where the macros are used.
`ifndef THP_SENSOR_COMPENSATION_TOP_DEFINES_SVH
`define THP_SENSOR_COMPENSATION_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define THP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("thp: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define THP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("thp: assertion failed");

`endif

// ----- hw/rtl/thp_pkg.sv -----
// Shared types, constants and helper functions of the compensation block.
// No dependencies; every RTL module of the block imports this package.
package thp_pkg;

  typedef struct packed {
    logic [19:0] raw_temperature;
    logic [19:0] raw_pressure;
    logic [15:0] raw_humidity;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               result_valid;
  } out_item_t;

  typedef struct packed {
    logic [47:0]        temperature_cal;
    logic [63:0]        pressure_cal_a;
    logic [63:0]        pressure_cal_b;
    logic signed [15:0] pressure_cal_c;
    logic [63:0]        humidity_cal;
  } cal_t;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;

  localparam logic [CfgIdxW-1:0] CFG_TEMPERATURE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PRESSURE_A  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_PRESSURE_B  = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PRESSURE_C  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_HUMIDITY    = 3'd4;

  localparam logic [63:0] TFINE_OFS    = 64'd128000;
  localparam logic [31:0] HFINE_OFS    = 32'd76800;
  localparam logic [63:0] PRES_BASE    = 64'd1048576;
  localparam logic [63:0] PRES_SCALE   = 64'd3125;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [31:0] HUM_RND_A    = 32'd16384;
  localparam logic [31:0] HUM_RND_B    = 32'd2097152;
  localparam logic [31:0] HUM_RND_C    = 32'd8192;
  localparam logic [31:0] HUM_RND_D    = 32'd32768;
  localparam logic [63:0] PRES_OFS_47  = 64'h0000_8000_0000_0000;

  function automatic logic [31:0] asr32(input logic [31:0] a, input logic [4:0] n);
    asr32 = $signed(a) >>> n;
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] a, input logic [5:0] n);
    asr64 = $signed(a) >>> n;
  endfunction

  function automatic logic [63:0] sx16(input logic [15:0] a);
    sx16 = {{48{a[15]}}, a};
  endfunction

  function automatic logic [63:0] sx32(input logic [31:0] a);
    sx32 = {{32{a[31]}}, a};
  endfunction

endpackage

// ----- hw/rtl/thp_front.sv -----
// Front end: calibration register file and input channel acceptance.
// Depends on thp_pkg; feeds the item queue.
module thp_front
  import thp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output in_item_t            q_item_o,
  output cal_t                cal_o
);

  cal_t cal_q, cal_d;

  always_comb begin
    cal_d = cal_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TEMPERATURE: cal_d.temperature_cal = cfg_wdata_i[47:0];
        CFG_PRESSURE_A:  cal_d.pressure_cal_a  = cfg_wdata_i;
        CFG_PRESSURE_B:  cal_d.pressure_cal_b  = cfg_wdata_i;
        CFG_PRESSURE_C:  cal_d.pressure_cal_c  = cfg_wdata_i[15:0];
        CFG_HUMIDITY:    cal_d.humidity_cal    = cfg_wdata_i;
        default:         cal_d = cal_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_q <= '0;
    end else begin
      cal_q <= cal_d;
    end
  end

  // An item is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign q_item_o   = in_item_i;
  assign cal_o      = cal_q;

endmodule

// ----- hw/rtl/thp_queue.sv -----
// Two-entry queue that decouples the front end from the compute sequencer.
// Depends on thp_pkg.
module thp_queue
  import thp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  output logic     valid_o,
  input  logic     pop_i,
  output in_item_t item_o
);

  in_item_t   mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

endmodule

// ----- hw/rtl/thp_back.sv -----
// Compute sequencer: shared 32x32 multiplier, bit-serial divider, output register.
// Depends on thp_pkg; pops items from thp_queue.
module thp_back
  import thp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cal_t      cal_i,
  input  logic      q_valid_i,
  input  in_item_t  q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_T1   = 5'd1;
  localparam logic [4:0] ST_T2   = 5'd2;
  localparam logic [4:0] ST_T3   = 5'd3;
  localparam logic [4:0] ST_TC   = 5'd4;
  localparam logic [4:0] ST_P1   = 5'd5;
  localparam logic [4:0] ST_P2   = 5'd6;
  localparam logic [4:0] ST_P3   = 5'd7;
  localparam logic [4:0] ST_P4   = 5'd8;
  localparam logic [4:0] ST_P5   = 5'd9;
  localparam logic [4:0] ST_P6   = 5'd10;
  localparam logic [4:0] ST_P7   = 5'd11;
  localparam logic [4:0] ST_DIV  = 5'd12;
  localparam logic [4:0] ST_DQ   = 5'd13;
  localparam logic [4:0] ST_P8   = 5'd14;
  localparam logic [4:0] ST_P9   = 5'd15;
  localparam logic [4:0] ST_P10  = 5'd16;
  localparam logic [4:0] ST_PF   = 5'd17;
  localparam logic [4:0] ST_H1   = 5'd18;
  localparam logic [4:0] ST_H2   = 5'd19;
  localparam logic [4:0] ST_H3   = 5'd20;
  localparam logic [4:0] ST_H4   = 5'd21;
  localparam logic [4:0] ST_H5   = 5'd22;
  localparam logic [4:0] ST_H6   = 5'd23;
  localparam logic [4:0] ST_H7   = 5'd24;
  localparam logic [4:0] ST_H8   = 5'd25;
  localparam logic [4:0] ST_HF   = 5'd26;
  localparam logic [4:0] ST_OUT  = 5'd27;

  localparam logic [1:0] PH_LO   = 2'd0;
  localparam logic [1:0] PH_X1   = 2'd1;
  localparam logic [1:0] PH_X2   = 2'd2;
  localparam logic [1:0] PH_WB   = 2'd3;

  logic [4:0]  state_q, state_d;
  logic [1:0]  ph_q, ph_d;
  logic [63:0] acc_q, acc_d;
  in_item_t    item_q, item_d;
  logic [31:0] tf_q, tf_d, w_q, w_d, v_q, v_d, left_q, left_d;
  logic [31:0] k_q, k_d, mm_q, mm_d, hv_q, hv_d, pres_q, pres_d;
  logic [15:0] temp_q, temp_d;
  logic [16:0] hum_q, hum_d;
  logic        valid_q, valid_d, neg_q, neg_d;
  logic [63:0] x1_q, x1_d, sq_q, sq_d, x2_q, x2_d, a_q, a_d;
  logic [63:0] num_q, num_d, quo_q, quo_d, q_q, q_d, s_q, s_d, y_q, y_d;
  logic [64:0] rem_q, rem_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  // Calibration fields.
  logic [31:0] t1, t2, t3, adc_t, h4, h5;
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  logic [7:0]  h1, h3, h6;
  logic [15:0] h2;
  logic [63:0] pres_span;

  assign t1    = {16'd0, cal_i.temperature_cal[15:0]};
  assign t2    = {{16{cal_i.temperature_cal[31]}}, cal_i.temperature_cal[31:16]};
  assign t3    = {{16{cal_i.temperature_cal[47]}}, cal_i.temperature_cal[47:32]};
  assign p1    = {48'd0, cal_i.pressure_cal_a[15:0]};
  assign p2    = sx16(cal_i.pressure_cal_a[31:16]);
  assign p3    = sx16(cal_i.pressure_cal_a[47:32]);
  assign p4    = sx16(cal_i.pressure_cal_a[63:48]);
  assign p5    = sx16(cal_i.pressure_cal_b[15:0]);
  assign p6    = sx16(cal_i.pressure_cal_b[31:16]);
  assign p7    = sx16(cal_i.pressure_cal_b[47:32]);
  assign p8    = sx16(cal_i.pressure_cal_b[63:48]);
  assign p9    = sx16(cal_i.pressure_cal_c);
  assign h1    = cal_i.humidity_cal[7:0];
  assign h2    = cal_i.humidity_cal[23:8];
  assign h3    = cal_i.humidity_cal[31:24];
  assign h4    = {{20{cal_i.humidity_cal[43]}}, cal_i.humidity_cal[43:32]};
  assign h5    = {{20{cal_i.humidity_cal[55]}}, cal_i.humidity_cal[55:44]};
  assign h6    = cal_i.humidity_cal[63:56];
  assign adc_t = {12'd0, item_q.raw_temperature};

  // Distance of the raw pressure from full scale; at most 2^20, so 33 bits
  // survive the shift by 31 into the 64-bit numerator.
  assign pres_span = PRES_BASE - {44'd0, item_q.raw_pressure};

  // Operand selection for the shared multiplier.
  logic [63:0] op_a, op_b;
  logic        is_mul, wide;

  always_comb begin
    op_a   = '0;
    op_b   = '0;
    is_mul = 1'b1;
    wide   = 1'b0;
    case (state_q)
      ST_T1: begin
        op_a = sx32((adc_t >> 3) - {t1[30:0], 1'b0});
        op_b = sx32(t2);
      end
      ST_T2: begin
        op_a = sx32((adc_t >> 4) - t1);
        op_b = sx32((adc_t >> 4) - t1);
      end
      ST_T3:  begin op_a = sx32(w_q);  op_b = sx32(t3); end
      ST_P1:  begin op_a = x1_q;  op_b = x1_q;       wide = 1'b1; end
      ST_P2:  begin op_a = sq_q;  op_b = p6;         wide = 1'b1; end
      ST_P3:  begin op_a = x1_q;  op_b = p5;         wide = 1'b1; end
      ST_P4:  begin op_a = sq_q;  op_b = p3;         wide = 1'b1; end
      ST_P5:  begin op_a = x1_q;  op_b = p2;         wide = 1'b1; end
      ST_P6:  begin op_a = a_q;   op_b = p1;         wide = 1'b1; end
      ST_P7:  begin op_a = num_q; op_b = PRES_SCALE; wide = 1'b1; end
      ST_P8:  begin op_a = p9;    op_b = s_q;        wide = 1'b1; end
      ST_P9:  begin op_a = y_q;   op_b = s_q;        wide = 1'b1; end
      ST_P10: begin op_a = p8;    op_b = q_q;        wide = 1'b1; end
      ST_H1:  begin op_a = sx32(h5);   op_b = sx32(v_q); end
      ST_H2:  begin op_a = sx32(v_q);  op_b = {56'd0, h3}; end
      ST_H3:  begin op_a = sx32(v_q);  op_b = {{56{h6[7]}}, h6}; end
      ST_H4:  begin op_a = sx32(mm_q); op_b = sx32(k_q); end
      ST_H5:  begin op_a = sx32(mm_q); op_b = sx16(h2); end
      ST_H6:  begin op_a = sx32(left_q); op_b = sx32(k_q); end
      ST_H7:  begin op_a = sx32(mm_q); op_b = sx32(mm_q); end
      ST_H8:  begin op_a = sx32(mm_q); op_b = {56'd0, h1}; end
      default: is_mul = 1'b0;
    endcase
  end

  // Low 64 bits of a 64x64 product from three 32x32 partial products; narrow products use the low one only.
  logic [31:0] mul_x, mul_y;
  logic [63:0] pp;

  always_comb begin
    case (ph_q)
      PH_X1:   begin mul_x = op_a[31:0];  mul_y = op_b[63:32]; end
      PH_X2:   begin mul_x = op_a[63:32]; mul_y = op_b[31:0];  end
      default: begin mul_x = op_a[31:0];  mul_y = op_b[31:0];  end
    endcase
  end

  assign pp = {32'd0, mul_x} * {32'd0, mul_y};

  always_comb begin
    case (ph_q)
      PH_LO:       acc_d = pp;
      PH_X1, PH_X2: acc_d = acc_q + {pp[31:0], 32'd0};
      default:     acc_d = acc_q;
    endcase
    if (!is_mul) begin
      acc_d = acc_q;
    end
  end

  logic        wb;
  logic [63:0] prod;
  logic [31:0] prod32;

  assign wb     = is_mul && (ph_q == PH_WB);
  assign prod   = acc_q;
  assign prod32 = acc_q[31:0];

  always_comb begin
    ph_d = ph_q;
    if (is_mul) begin
      if (ph_q == PH_LO && !wide) begin
        ph_d = PH_WB;
      end else begin
        ph_d = ph_q + 2'd1;
      end
    end
  end

  // Divider step, temperature rounding, pressure finishing and humidity clamping.
  logic [64:0] rem_sh;
  logic        ge;
  logic [63:0] qv, pv;
  logic [31:0] tm, tvs, hum_c, h1v;

  assign rem_sh = {rem_q[63:0], quo_q[63]};
  assign ge     = rem_sh >= {1'b0, a_q};
  assign qv     = neg_q ? (64'd0 - quo_q) : quo_q;
  assign pv     = asr64(y_q, 6'd8) + {p7[59:0], 4'd0};
  assign tm     = {tf_q[29:0], 2'd0} + tf_q + 32'd128;
  assign tvs    = asr32(tm, 5'd8);
  assign h1v    = $signed(hv_q) < 0 ? 32'd0 : hv_q;
  assign hum_c  = ($signed(h1v) > $signed(HUM_MAX)) ? HUM_MAX : h1v;

  always_comb begin
    state_d     = state_q;
    item_d      = item_q;
    tf_d        = tf_q;
    w_d         = w_q;
    v_d         = v_q;
    left_d      = left_q;
    k_d         = k_q;
    mm_d        = mm_q;
    hv_d        = hv_q;
    pres_d      = pres_q;
    temp_d      = temp_q;
    hum_d       = hum_q;
    valid_d     = valid_q;
    neg_d       = neg_q;
    x1_d        = x1_q;
    sq_d        = sq_q;
    x2_d        = x2_q;
    a_d         = a_q;
    num_d       = num_q;
    quo_d       = quo_q;
    q_d         = q_q;
    s_d         = s_q;
    y_d         = y_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          state_d = ST_T1;
        end
      end
      ST_T1: if (wb) begin tf_d = asr32(prod32, 5'd11); state_d = ST_T2; end
      ST_T2: if (wb) begin w_d = asr32(prod32, 5'd12); state_d = ST_T3; end
      ST_T3: if (wb) begin tf_d = tf_q + asr32(prod32, 5'd14); state_d = ST_TC; end
      ST_TC: begin
        if ($signed(tvs) > 32'sd32767) begin
          temp_d = 16'h7FFF;
        end else if ($signed(tvs) < -32'sd32768) begin
          temp_d = 16'h8000;
        end else begin
          temp_d = tvs[15:0];
        end
        x1_d    = sx32(tf_q) - TFINE_OFS;
        state_d = ST_P1;
      end
      ST_P1: if (wb) begin sq_d = prod; state_d = ST_P2; end
      ST_P2: if (wb) begin x2_d = prod; state_d = ST_P3; end
      ST_P3: if (wb) begin
        x2_d    = x2_q + {prod[46:0], 17'd0} + {p4[28:0], 35'd0};
        state_d = ST_P4;
      end
      ST_P4: if (wb) begin a_d = asr64(prod, 6'd8); state_d = ST_P5; end
      ST_P5: if (wb) begin
        a_d     = a_q + {prod[51:0], 12'd0} + PRES_OFS_47;
        state_d = ST_P6;
      end
      ST_P6: if (wb) begin
        a_d     = asr64(prod, 6'd33);
        num_d   = {pres_span[32:0], 31'd0} - x2_q;
        state_d = ST_P7;
      end
      ST_P7: if (wb) begin
        if (a_q == 64'd0) begin
          // Zero divisor: pressure and humidity are reported as zero, invalid.
          pres_d  = '0;
          hum_d   = '0;
          valid_d = 1'b0;
          state_d = ST_OUT;
        end else begin
          quo_d   = prod[63] ? (64'd0 - prod) : prod;
          a_d     = a_q[63] ? (64'd0 - a_q) : a_q;
          neg_d   = prod[63] ^ a_q[63];
          rem_d   = '0;
          dcnt_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? (rem_sh - {1'b0, a_q}) : rem_sh;
        quo_d  = {quo_q[62:0], ge};
        dcnt_d = dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          state_d = ST_DQ;
        end
      end
      ST_DQ: begin
        q_d     = qv;
        s_d     = asr64(qv, 6'd13);
        state_d = ST_P8;
      end
      ST_P8:  if (wb) begin y_d = prod; state_d = ST_P9; end
      ST_P9:  if (wb) begin y_d = asr64(prod, 6'd25); state_d = ST_P10; end
      ST_P10: if (wb) begin y_d = y_q + asr64(prod, 6'd19) + q_q; state_d = ST_PF; end
      ST_PF: begin
        if (pv[63]) begin
          pres_d = '0;
        end else if (pv[62:32] != 31'd0) begin
          pres_d = 32'hFFFF_FFFF;
        end else begin
          pres_d = pv[31:0];
        end
        v_d     = tf_q - HFINE_OFS;
        state_d = ST_H1;
      end
      ST_H1: if (wb) begin
        left_d  = asr32({2'd0, item_q.raw_humidity, 14'd0} - {h4[11:0], 20'd0}
                        - prod32 + HUM_RND_A, 5'd15);
        state_d = ST_H2;
      end
      ST_H2: if (wb) begin k_d = asr32(prod32, 5'd11) + HUM_RND_D; state_d = ST_H3; end
      ST_H3: if (wb) begin mm_d = asr32(prod32, 5'd10); state_d = ST_H4; end
      ST_H4: if (wb) begin mm_d = asr32(prod32, 5'd10) + HUM_RND_B; state_d = ST_H5; end
      ST_H5: if (wb) begin k_d = asr32(prod32 + HUM_RND_C, 5'd14); state_d = ST_H6; end
      ST_H6: if (wb) begin
        hv_d    = prod32;
        mm_d    = asr32(prod32, 5'd15);
        state_d = ST_H7;
      end
      ST_H7: if (wb) begin mm_d = asr32(prod32, 5'd7); state_d = ST_H8; end
      ST_H8: if (wb) begin hv_d = hv_q - asr32(prod32, 5'd4); state_d = ST_HF; end
      ST_HF: begin
        hum_d   = hum_c[28:12];
        valid_d = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d             = 1'b1;
          out_d.temperature_centi = temp_q;
          out_d.pressure_q24_8    = pres_q;
          out_d.humidity_q22_10   = hum_q;
          out_d.result_valid      = valid_q;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_LO;
      out_valid_q <= 1'b0;
      dcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      dcnt_q      <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    item_q <= item_d;
    tf_q   <= tf_d;
    w_q    <= w_d;
    v_q    <= v_d;
    left_q <= left_d;
    k_q    <= k_d;
    mm_q   <= mm_d;
    hv_q   <= hv_d;
    pres_q <= pres_d;
    temp_q <= temp_d;
    hum_q  <= hum_d;
    valid_q <= valid_d;
    neg_q  <= neg_d;
    x1_q   <= x1_d;
    sq_q   <= sq_d;
    x2_q   <= x2_d;
    a_q    <= a_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    q_q    <= q_d;
    s_q    <= s_d;
    y_q    <= y_d;
    rem_q  <= rem_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ----- hw/rtl/thp_sensor_compensation_top.sv -----
// Top level of the temperature, pressure and humidity compensation block.
// Depends on thp_pkg, thp_front, thp_queue and thp_back.
//
//   Channel   Direction  Handshake                   Payload
//   cfg       in         cfg_we_i (no wait)          cfg_index_i, cfg_wdata_i
//   in        in         in_valid_i / in_stall_o     in_item_i  (in_item_t)
//   out       out        out_valid_o / out_stall_i   out_item_o (out_item_t)
//
// The 64-step restoring divider and the single shared 32x32 multiplier, which
// forms a 32-bit product from one partial product and a 64-bit product from three,
// set the time a transaction takes from queue to output register.
// A transaction with a zero pressure divisor skips the divider and all later steps.
// Reset clears the calibration registers, the queue and the output valid flag.
// The two-entry queue keeps accepting input transactions, as long as it has room,
// while the sequencer works or while a finished result waits under out_stall_i.
module thp_sensor_compensation_top
  import thp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_item_o
);

  cal_t     cal;
  logic     q_full, q_push, q_valid, q_pop;
  in_item_t q_in_item, q_out_item;

  // Front end: calibration registers and input acceptance.
  thp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (q_in_item),
    .cal_o       (cal)
  );

  // Queue between acceptance and computation.
  thp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in_item),
    .full_o  (q_full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .item_o  (q_out_item)
  );

  // Back end: sequenced compensation arithmetic and the output register.
  thp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cal_i       (cal),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- hw/rtl/thp_checker.sv -----
// Port-level checks of the compensation block, bound to the top level.
// Depends on thp_pkg and thp_sensor_compensation_top_defines.svh.
`include "thp_sensor_compensation_top_defines.svh"

module thp_checker
  import thp_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // A stalled result stays and holds its payload.
  `THP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

  // An invalid result reports zero pressure.
  `THP_ASSERT_NOW(a_inv_pres, out_valid_o && !out_item_o.result_valid, out_item_o.pressure_q24_8 == 32'd0)

  // An invalid result reports zero humidity.
  `THP_ASSERT_NOW(a_inv_hum, out_valid_o && !out_item_o.result_valid, out_item_o.humidity_q22_10 == 17'd0)

  // Humidity never exceeds one hundred percent.
  `THP_ASSERT_NOW(a_hum_max, out_valid_o, out_item_o.humidity_q22_10 <= 17'd102400)

endmodule

bind thp_sensor_compensation_top thp_checker u_checker (.*);
